// ===== sv/bgm_pkg.sv =====
// shared constants, types and the exp2 coefficient table for the geometric mean block
`timescale 1ns / 1ps
package bgm_pkg;

  // configuration register indexes
  localparam logic CFG_WINDOW = 1'b0;
  localparam logic CFG_GAIN   = 1'b1;

  localparam int FRAC_BITS = 16;   // fraction bits of log2 values
  localparam int ACC_BITS  = 31;   // Q1.30 exp2 accumulator, always below 2.0
  localparam int COEF_BITS = 32;

  typedef logic [FRAC_BITS-1:0][COEF_BITS-1:0] exp_tab_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] bv;
    x  = x_in;
    r  = '0;
    bv = 64'h1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (x >= r + bv) begin
        x = x - (r + bv);
        r = (r >> 1) + bv;
      end else begin
        r = r >> 1;
      end
      bv = bv >> 2;
    end
    return r;
  endfunction

  // entry i holds 2^(2^-(i+1)) in Q2.30
  function automatic exp_tab_t exp_table();
    logic [63:0] c;
    exp_tab_t    t;
    c = 64'h8000_0000;
    for (int i = 0; i < FRAC_BITS; i++) begin
      c    = isqrt64(c << 30);
      t[i] = c[COEF_BITS-1:0];
    end
    return t;
  endfunction

  localparam exp_tab_t EXP_TAB = exp_table();

endpackage

// ===== sv/bgm_fifo.sv =====
// two-entry queue carrying finished block sums from the front to the back
`timescale 1ns / 1ps
module bgm_fifo #(
  parameter int W = 34
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  output logic         full,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic         empty,
  output logic [W-1:0] rdata
);
  logic [W-1:0] mem_r [2];
  logic         wptr_r, wptr_nxt;
  logic         rptr_r, rptr_nxt;
  logic [1:0]   cnt_r, cnt_nxt;
  logic         do_push, do_pop;

  assign full    = cnt_r == 2'd2;
  assign empty   = cnt_r == 2'd0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = do_push ? ~wptr_r : wptr_r;
    rptr_nxt = do_pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count out of range");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 || cnt_r == 2'd2) |-> (wptr_r == rptr_r))
    else $error("queue pointers disagree with count");
endmodule

// ===== sv/bgm_front.sv =====
// sample intake: log2 by repeated squaring and per-block log sum accumulation
`timescale 1ns / 1ps
module bgm_front #(
  parameter int SB = 16,
  parameter int NW = 11,
  parameter int LW = 33
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [SB-1:0]        in_sample,
  input  logic [NW-1:0]        n_eff,
  output logic                 q_push,
  input  logic                 q_full,
  output logic [LW:0]          q_wdata
);
  import bgm_pkg::*;

  localparam int PW = $clog2(SB);

  typedef enum logic [2:0] {F_IDLE, F_NORM, F_LOG, F_ACC, F_PUSH} fstate_t;

  fstate_t               state_r;
  logic [SB-1:0]         s_r;
  logic [PW-1:0]         p_r, p_nxt;
  logic [15:0]           m_r, m_nxt;
  logic [FRAC_BITS-1:0]  frac_r;
  logic [3:0]            step_r;
  logic signed [LW-1:0]  sum_r;
  logic [NW-1:0]         count_r;
  logic                  zero_r;
  logic                  last_r;

  logic [SB+14:0]        norm_w;
  logic [31:0]           sq_full;
  logic [16:0]           sq;
  logic signed [LW-1:0]  ipart;
  logic signed [LW-1:0]  log_val;
  logic [NW:0]           count_inc;

  // leading one and Q1.15 normalization
  always_comb begin
    p_nxt = '0;
    for (int i = 0; i < SB; i++) begin
      if (s_r[i]) p_nxt = PW'(i);
    end
    norm_w = {s_r, 15'b0} >> p_nxt;
    m_nxt  = norm_w[15:0];
  end

  always_comb begin
    sq_full   = m_r * m_r;
    sq        = sq_full[31:15];
    ipart     = $signed(LW'({1'b0, p_r})) - $signed(LW'(8));
    log_val   = (ipart <<< FRAC_BITS) + $signed(LW'(frac_r));
    count_inc = {1'b0, count_r} + (NW+1)'(1);
  end

  assign in_full = state_r != F_IDLE;
  assign q_push  = state_r == F_PUSH;
  assign q_wdata = {zero_r, sum_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      sum_r   <= '0;
      count_r <= '0;
      zero_r  <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (in_push) begin
            s_r     <= in_sample;
            state_r <= F_NORM;
          end
        end
        F_NORM: begin
          p_r    <= p_nxt;
          m_r    <= m_nxt;
          frac_r <= '0;
          step_r <= '0;
          if (s_r == '0) begin
            zero_r  <= 1'b1;
            state_r <= F_ACC;
          end else begin
            state_r <= F_LOG;
          end
        end
        F_LOG: begin
          // one fraction bit per squaring
          m_r    <= sq[16] ? sq[16:1] : sq[15:0];
          frac_r <= {frac_r[FRAC_BITS-2:0], sq[16]};
          step_r <= step_r + 4'd1;
          if (step_r == 4'd15) state_r <= F_ACC;
        end
        F_ACC: begin
          if (s_r != '0) sum_r <= sum_r + log_val;
          count_r <= count_inc[NW-1:0];
          if (count_inc >= {1'b0, n_eff}) begin
            state_r <= F_PUSH;
          end else begin
            state_r <= F_IDLE;
          end
          last_r <= count_inc >= {1'b0, n_eff};
        end
        F_PUSH: begin
          if (!q_full) begin
            sum_r   <= '0;
            count_r <= '0;
            zero_r  <= 1'b0;
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

  a_push_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == F_PUSH && !q_full) |=> (count_r == '0 && !zero_r && state_r == F_IDLE))
    else $error("block state not cleared after hand-off");
  a_push_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == F_PUSH) |-> last_r)
    else $error("hand-off without block end");
endmodule

// ===== sv/bgm_back.sv =====
// block finish: floor divide, exp2, gain scaling and saturation, with result register
`timescale 1ns / 1ps
module bgm_back #(
  parameter int NW = 11,
  parameter int LW = 33
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         q_empty,
  output logic         q_pop,
  input  logic [LW:0]  q_rdata,
  input  logic [NW-1:0] n_eff,
  input  logic [15:0]  gain,
  output logic         out_empty,
  input  logic         out_pop,
  output logic [31:0]  out_mean_value
);
  import bgm_pkg::*;

  localparam int IW  = LW - FRAC_BITS;
  localparam int CW  = $clog2(LW);
  localparam int PRW = 16 + ACC_BITS;
  localparam int WW  = PRW + 16;

  typedef enum logic [2:0] {B_IDLE, B_DIV, B_FIX, B_EXP, B_MUL, B_OUT} bstate_t;

  bstate_t              state_r;
  logic [LW-1:0]        a_r;
  logic [NW-1:0]        rem_r;
  logic                 neg_r;
  logic                 zero_r;
  logic [CW-1:0]        dcnt_r;
  logic [FRAC_BITS-1:0] f_r;
  logic signed [IW+1:0] t_r;
  logic [ACC_BITS-1:0]  acc_r;
  logic [3:0]           ecnt_r;
  logic [PRW-1:0]       prod_r;
  logic                 out_valid_r;
  logic [31:0]          out_r;

  logic signed [LW-1:0] sum_in;
  logic [NW:0]          rem_sh;
  logic                 qbit;
  logic signed [LW-1:0] q_val;
  logic signed [IW-1:0] ip;
  logic [63:0]          emul;
  logic [WW-1:0]        wide;
  logic [WW-1:0]        shifted;
  logic [31:0]          v;

  assign sum_in = $signed(q_rdata[LW-1:0]);
  assign q_pop  = state_r == B_IDLE && !q_empty;

  always_comb begin
    rem_sh = {rem_r, a_r[LW-1]};
    qbit   = rem_sh >= {1'b0, n_eff};
    // floor for negative sums: round the magnitude quotient up
    q_val  = neg_r ? -($signed(a_r) + $signed(LW'(rem_r != '0))) : $signed(a_r);
    ip     = q_val[LW-1:FRAC_BITS];
    emul   = 64'(acc_r) * 64'(EXP_TAB[ecnt_r]);
    wide   = {prod_r, 16'b0};
    shifted = wide >> $unsigned(t_r);
    if (zero_r) begin
      v = '0;
    end else if (t_r <= 0) begin
      v = (prod_r == '0) ? 32'd0 : 32'hFFFF_FFFF;
    end else if (t_r >= $signed((IW+2)'(WW))) begin
      v = '0;
    end else if (shifted[WW-1:32] != '0) begin
      v = 32'hFFFF_FFFF;
    end else begin
      v = shifted[31:0];
    end
  end

  assign out_empty      = !out_valid_r;
  assign out_mean_value = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_pop && out_valid_r) out_valid_r <= 1'b0;
      case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            neg_r   <= sum_in[LW-1];
            a_r     <= sum_in[LW-1] ? LW'(-sum_in) : LW'(sum_in);
            zero_r  <= q_rdata[LW];
            rem_r   <= '0;
            dcnt_r  <= CW'(LW - 1);
            state_r <= B_DIV;
          end
        end
        B_DIV: begin
          rem_r  <= qbit ? NW'(rem_sh - {1'b0, n_eff}) : rem_sh[NW-1:0];
          a_r    <= {a_r[LW-2:0], qbit};
          dcnt_r <= dcnt_r - CW'(1);
          if (dcnt_r == '0) state_r <= B_FIX;
        end
        B_FIX: begin
          f_r     <= q_val[FRAC_BITS-1:0];
          t_r     <= $signed((IW+2)'(38)) - $signed({{2{ip[IW-1]}}, ip});
          acc_r   <= ACC_BITS'(1) << 30;
          ecnt_r  <= '0;
          state_r <= B_EXP;
        end
        B_EXP: begin
          if (f_r[FRAC_BITS-1]) acc_r <= emul[60:30];
          f_r    <= {f_r[FRAC_BITS-2:0], 1'b0};
          ecnt_r <= ecnt_r + 4'd1;
          if (ecnt_r == 4'd15) state_r <= B_MUL;
        end
        B_MUL: begin
          prod_r  <= PRW'(gain) * PRW'(acc_r);
          state_r <= B_OUT;
        end
        B_OUT: begin
          if (!out_valid_r) begin
            out_r       <= v;
            out_valid_r <= 1'b1;
            state_r     <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  a_out_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_OUT && !out_valid_r) |=> out_valid_r)
    else $error("finished result not registered");
  a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_OUT && !out_valid_r && zero_r) |=> (out_r == 32'd0))
    else $error("zero sample block gave nonzero result");
endmodule

// ===== sv/block_geometric_mean_core.sv =====
// top level of the block geometric mean core
//
//  channel   direction  handshake         payload
//  in_       request    in_push / in_full  in_sample
//  out_      result     out_empty/out_pop  out_mean_value
//  cfg_      write      cfg_we             cfg_index, cfg_wdata
//
// a nonzero sample passes the front as accept, normalize, 16 squaring
// steps of the log2 unit, then the accumulate; a zero sample skips the squaring steps
// the last sample of a block adds a hand-off state, held while the queue is full
// block finish in the back is a serial divide, 16 exp2 multiplies and a gain
// multiply, overlapped with the next block via a 2-entry queue
// reset is synchronous and active low; it restores window 10, gain 1.0
// in_full stays high while the front is busy, also while its hand-off waits on a full queue;
// an unpopped result holds the back, then fills the queue and stalls the input
`timescale 1ns / 1ps
module block_geometric_mean_core #(
  parameter int MAX_WINDOW  = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_push,
  output logic                   in_full,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  output logic                   out_empty,
  input  logic                   out_pop,
  output logic [31:0]            out_mean_value,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [15:0]            cfg_wdata
);
  import bgm_pkg::*;

  localparam int NW = $clog2(MAX_WINDOW + 1);
  localparam int LW = FRAC_BITS + 1 + $clog2(SAMPLE_BITS) + NW + 1;

  logic [10:0]   window_r;
  logic [15:0]   gain_r;
  logic [NW-1:0] n_eff;
  logic          q_push, q_full, q_pop, q_empty;
  logic [LW:0]   q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= 11'd10;
      gain_r   <= 16'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW: window_r <= cfg_wdata[10:0];
        CFG_GAIN:   gain_r   <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  // zero means one, above the maximum means the maximum
  always_comb begin
    if (window_r == '0) begin
      n_eff = NW'(1);
    end else if (32'(window_r) > 32'(MAX_WINDOW)) begin
      n_eff = NW'(MAX_WINDOW);
    end else begin
      n_eff = NW'(window_r);
    end
  end

  bgm_front #(.SB(SAMPLE_BITS), .NW(NW), .LW(LW)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_sample (in_sample),
    .n_eff     (n_eff),
    .q_push    (q_push),
    .q_full    (q_full),
    .q_wdata   (q_wdata)
  );

  bgm_fifo #(.W(LW + 1)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .full  (q_full),
    .wdata (q_wdata),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  bgm_back #(.NW(NW), .LW(LW)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .q_rdata        (q_rdata),
    .n_eff          (n_eff),
    .gain           (gain_r),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_mean_value (out_mean_value)
  );
endmodule

// ===== tb/sv/tb_block_geometric_mean_core.sv =====
// testbench for the block geometric mean core: directed and random sample streams checked against a predictor
`timescale 1ns / 1ps
module tb_block_geometric_mean_core;
  import bgm_pkg::*;

  localparam int MAX_WIN = 1024;
  localparam longint CYCLE_LIMIT = 3000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [15:0] in_sample = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [31:0] out_mean_value;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_WINDOW;
  logic [15:0] cfg_wdata = '0;

  block_geometric_mean_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_sample(in_sample),
    .out_empty(out_empty), .out_pop(out_pop), .out_mean_value(out_mean_value),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [10:0]  win_reg;
  logic [15:0]  gain_reg;
  longint       log_acc;
  int           cnt;
  bit           saw_zero;

  logic [15:0]  sample_q[$];
  logic [31:0]  mean_q[$];
  int           errors = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  int           hold_off = 0;
  longint       cycles = 0;

  logic [15:0]  directed_s [10] = '{16'h0001, 16'hFFFF, 16'h0100, 16'h8000, 16'h00FF,
                                    16'h0000, 16'h7FFF, 16'h0002, 16'h5555, 16'hAAAA};

  function automatic longint unsigned int_sqrt(longint unsigned x_in);
    longint unsigned x, r, b;
    x = x_in; r = 0; b = 64'h1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint sample_log2(logic [15:0] s);
    int p;
    longint unsigned m;
    longint fr;
    p = 0; fr = 0;
    for (int i = 0; i < 16; i++) if (s[i]) p = i;
    m = (p >= 15) ? (64'(s) >> (p - 15)) : (64'(s) << (15 - p));
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 15;
      fr = fr << 1;
      if (m >= 65536) begin
        m >>= 1;
        fr |= 1;
      end
    end
    return longint'(p - 8) * 65536 + fr;
  endfunction

  function automatic logic [31:0] block_mean(longint n);
    longint q, u, ip, sh;
    longint unsigned acc, c, prod, v;
    if (saw_zero) return '0;
    if (log_acc >= 0) q = log_acc / n;
    else q = -((-log_acc + n - 1) / n);
    u = q + (longint'(64) << 16);
    ip = u / 65536 - 64;
    acc = 64'h1 << 30;
    c = 64'h1 << 31;
    for (int i = 1; i <= 16; i++) begin
      c = int_sqrt(c << 30);
      if (((u % 65536) >> (16 - i)) & 1) acc = (acc * c) >> 30;
    end
    prod = gain_reg * acc;
    sh = 22 - ip;
    if (sh >= 63) v = 0;
    else if (sh >= 0) v = prod >> sh;
    else if (sh <= -16) v = (prod == 0) ? 0 : 64'hFFFF_FFFF;
    else v = prod << (-sh);
    if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
    return v[31:0];
  endfunction

  task automatic predict_sample(logic [15:0] s);
    longint n;
    n = (win_reg == 0) ? 1 : ((win_reg > MAX_WIN) ? MAX_WIN : win_reg);
    if (s == 0) saw_zero = 1;
    else log_acc += sample_log2(s);
    cnt++;
    if (cnt >= n) begin
      mean_q = {mean_q, block_mean(n)};
      log_acc = 0;
      cnt = 0;
      saw_zero = 0;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_push && !in_full) begin
        predict_sample(in_sample);
        void'(sample_q.pop_front());
      end
      if ((in_push && !in_full) || !in_push) begin
        if (sample_q.size() > (in_push && !in_full ? 0 : 0) &&
            $urandom_range(99) >= send_idle_pct) begin
          in_push <= 1'b1;
          in_sample <= sample_q[0];
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        if (mean_q.size() == 0) begin
          errors++;
          $display("%0t unexpected mean_value: expected none, actual %h", $time,
                   out_mean_value);
        end else begin
          if (out_mean_value !== mean_q[0]) begin
            errors++;
            $display("%0t mean_value mismatch: expected %h, actual %h", $time,
                     mean_q[0], out_mean_value);
          end
          void'(mean_q.pop_front());
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic write_reg(logic idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_WINDOW) win_reg = val[10:0];
    else gain_reg = val;
  endtask

  // samples are consumed one per request; wait until the block is idle again
  task automatic drain();
    while (sample_q.size() != 0 || in_push || mean_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(7))
      0: return '0;
      1: return 16'hFFFF;
      2: return 16'(1 << $urandom_range(15));
      3: return 16'($urandom_range(255, 1));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_phase(int items, logic [10:0] w, logic [15:0] g);
    drain();
    write_reg(CFG_WINDOW, 16'(w));
    write_reg(CFG_GAIN, g);
    for (int i = 0; i < items; i++) sample_q = {sample_q, rand_sample()};
  endtask

  initial begin
    win_reg = 11'd10; gain_reg = 16'd256;
    log_acc = 0; cnt = 0; saw_zero = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    // directed: reset window, field extremes, zero sample
    foreach (directed_s[k]) sample_q = {sample_q, directed_s[k]};
    drain();
    // window 1, max gain, on large, small and zero samples
    write_reg(CFG_WINDOW, 16'd1);
    write_reg(CFG_GAIN, 16'hFFFF);
    sample_q = {sample_q, 16'hFFFF, 16'h0001, 16'h0000, 16'h0100};
    drain();
    // window zero acts as one, zero gain, window above the maximum
    write_reg(CFG_WINDOW, 16'd0);
    write_reg(CFG_GAIN, 16'd0);
    sample_q = {sample_q, 16'h1234, 16'hFFFF};
    drain();
    write_reg(CFG_WINDOW, 16'h07FF);
    write_reg(CFG_GAIN, 16'd256);
    for (int i = 0; i < 30; i++) sample_q = {sample_q, 16'($urandom_range(65535, 1))};
    // shorten window mid-block: block ends at once on the next sample
    drain();
    write_reg(CFG_WINDOW, 16'd8);
    sample_q = {sample_q, 16'h0300, 16'h0500, 16'h0700};
    drain();
    write_reg(CFG_WINDOW, 16'd2);
    sample_q = {sample_q, 16'h0900, 16'h0B00};
    // random phases
    send_idle_pct = 18; recv_idle_pct = 67;
    random_phase(140, 11'd3, 16'($urandom));
    random_phase(90, 11'd1, 16'hFFFF);
    // long receiver hold-off so the block-sum queue fills and input stalls
    random_phase(60, 11'd1, 16'd256);
    hold_off = 3000;
    send_idle_pct = 67; recv_idle_pct = 18;
    random_phase(140, 11'd5, 16'($urandom));
    random_phase(90, 11'd1024, 16'd384);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(140, 11'd2, 16'($urandom));
    random_phase(90, 11'($urandom_range(16, 1)), 16'd256);
    drain();
    repeat (200) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/bgm_pkg.sv
sv/bgm_fifo.sv
sv/bgm_front.sv
sv/bgm_back.sv
sv/block_geometric_mean_core.sv
tb/sv/tb_block_geometric_mean_core.sv
